// ----- design/indexed_min_heap_key_update_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed min-heap
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_KEY_UPDATE_ASSERT_SVH
`define INDEXED_MIN_HEAP_KEY_UPDATE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define IMHK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, implies another in the same cycle.
`define IMHK_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/imhk_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Sizes, types and codes used by the heap sequencer.
// ----------------------------------------------------------------------------
package imhk_pkg;

  localparam int CAPACITY  = 1024;
  localparam int COST_BITS = 31;
  localparam int NCOLS     = 1024;

  localparam int COL_W  = $clog2(NCOLS);
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  typedef logic [COL_W-1:0]     col_t;
  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef struct packed {
    col_t  col;
    cost_t cost;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  // Heap slots count from one; the memory counts from zero.
  function automatic addr_t slot_addr(slot_idx_t s);
    slot_idx_t d;
    d = s - slot_idx_t'(1);
    return d[ADDR_W-1:0];
  endfunction

endpackage

// ----- design/imhk_if.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap channels
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface imhk_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [9:0]  column;
  logic [30:0] new_cost;

  modport source (output valid, op, column, new_cost, input ready);
  modport sink   (input valid, op, column, new_cost, output ready);
endinterface

interface imhk_rsp_if;
  logic        valid;
  logic        ready;
  logic [9:0]  min_column;
  logic [30:0] min_cost;
  logic [10:0] entry_count;
  logic [1:0]  status;

  modport source (output valid, min_column, min_cost, entry_count, status, input ready);
  modport sink   (input valid, min_column, min_cost, entry_count, status, output ready);
endinterface

// ----- design/imhk_ram.sv -----
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imhk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/indexed_min_heap_key_update.sv -----
// ----------------------------------------------------------------------------
// Indexed min-heap with key update
// Binary min-heap of (column, cost) pairs with a column-to-slot map.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  ---------+-----------+------------------------------------------------
//  req      | in        | op, column, new_cost
//  rsp      | out       | min_column, min_cost, entry_count, status
//
//  One request is handled at a time. Through the single read port of the
//  heap memory, a sift-up reads each parent in turn and a sift-down reads
//  the left child and, if there is one, the right child at each level.
//  After reset a clearing pass over all 1024 columns marks each one absent in
//  the position map; no request is taken until it ends.
//  The result sits in an output register, so a stalled response does not
//  stop the next request from starting; it waits only at its own result.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_key_update_assert.svh"

module indexed_min_heap_key_update
  import imhk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  imhk_req_if.sink  req,
  imhk_rsp_if.source rsp
);

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MAP   = 11'b00000000010,
    S_UPCHK = 11'b00000000100,
    S_UP    = 11'b00000001000,
    S_UPW   = 11'b00000010000,
    S_DN    = 11'b00000100000,
    S_DNL   = 11'b00001000000,
    S_DNR   = 11'b00010000000,
    S_PLACE = 11'b00100000000,
    S_ROOT  = 11'b01000000000,
    S_ROOTW = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  slot_idx_t  size, size_next;
  slot_idx_t  k, k_next;
  slot_idx_t  j, j_next;
  logic       op, op_next;
  col_t       col, col_next;
  cost_t      cost, cost_next;
  slot_t      left, left_next;
  logic [1:0] status, status_next;
  col_t       clr_cnt, clr_cnt_next;
  logic       clr_done, clr_done_next;

  logic        out_valid, out_valid_next;
  col_t        out_col, out_col_next;
  cost_t       out_cost, out_cost_next;
  slot_idx_t   out_count, out_count_next;
  logic [1:0]  out_status, out_status_next;

  // Heap memory port signals.
  logic  h_we, h_re;
  addr_t h_wa, h_ra;
  slot_t h_wd, h_rd;
  logic [SLOT_BITS-1:0] h_rd_raw;

  // Position map port signals; zero means absent, else slot number.
  logic      m_we, m_re;
  col_t      m_wa, m_ra;
  slot_idx_t m_wd, m_rd;

  // Child chosen on the way down.
  slot_t       ch;
  slot_idx_t   ch_slot;
  logic [SLOT_W:0] j2;

  imhk_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_wa),
    .wdata (h_wd),
    .re    (h_re),
    .raddr (h_ra),
    .rdata (h_rd_raw)
  );
  assign h_rd = slot_t'(h_rd_raw);

  imhk_ram #(.WIDTH(SLOT_W), .DEPTH(NCOLS)) u_map (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_wa),
    .wdata (m_wd),
    .re    (m_re),
    .raddr (m_ra),
    .rdata (m_rd)
  );

  assign req.ready = (state == S_IDLE) && clr_done;

  assign rsp.valid       = out_valid;
  assign rsp.min_column  = out_col;
  assign rsp.min_cost    = 31'(out_cost);
  assign rsp.entry_count = 11'(out_count);
  assign rsp.status      = out_status;

  assign j2 = {k, 1'b0};

  always_comb begin
    state_next      = state;
    size_next       = size;
    k_next          = k;
    j_next          = j;
    op_next         = op;
    col_next        = col;
    cost_next       = cost;
    left_next       = left;
    status_next     = status;
    clr_cnt_next    = clr_cnt;
    clr_done_next   = clr_done;
    out_valid_next  = out_valid && !rsp.ready;
    out_col_next    = out_col;
    out_cost_next   = out_cost;
    out_count_next  = out_count;
    out_status_next = out_status;

    h_we = 1'b0;
    h_wa = slot_addr(k);
    h_wd = '{col: col, cost: cost};
    h_re = 1'b0;
    h_ra = slot_addr(k >> 1);
    m_we = 1'b0;
    m_wa = col;
    m_wd = k;
    m_re = 1'b0;
    m_ra = req.column;

    ch      = left;
    ch_slot = j;

    // Clearing pass over the position map after reset.
    if (!clr_done) begin
      m_we         = 1'b1;
      m_wa         = clr_cnt;
      m_wd         = '0;
      clr_cnt_next = clr_cnt + col_t'(1);
      if (clr_cnt == col_t'(NCOLS - 1)) begin
        clr_done_next = 1'b1;
      end
    end

    unique case (state)
      S_IDLE: begin
        if (req.valid && clr_done) begin
          op_next   = req.op;
          col_next  = req.column;
          cost_next = cost_t'(req.new_cost);
          m_re      = 1'b1;
          state_next = S_MAP;
        end
      end

      S_MAP: begin
        status_next = ST_OK;
        if (op == OP_INSERT) begin
          if (m_rd != '0) begin
            status_next = ST_DUP;
            state_next  = S_ROOT;
          end else if (size == slot_idx_t'(CAPACITY)) begin
            status_next = ST_FULL;
            state_next  = S_ROOT;
          end else begin
            size_next  = size + slot_idx_t'(1);
            k_next     = size + slot_idx_t'(1);
            state_next = S_UP;
          end
        end else begin
          if (m_rd == '0 || m_rd > size) begin
            status_next = ST_ABSENT;
            state_next  = S_ROOT;
          end else begin
            k_next = m_rd;
            if (m_rd == slot_idx_t'(1)) begin
              state_next = S_DN;
            end else begin
              h_re       = 1'b1;
              h_ra       = slot_addr(m_rd >> 1);
              state_next = S_UPCHK;
            end
          end
        end
      end

      // An update starts to move up only if the parent is strictly dearer.
      S_UPCHK: begin
        if (h_rd.cost > cost) begin
          h_we       = 1'b1;
          h_wd       = h_rd;
          m_we       = 1'b1;
          m_wa       = h_rd.col;
          k_next     = k >> 1;
          state_next = S_UP;
        end else begin
          state_next = S_DN;
        end
      end

      S_UP: begin
        if (k > slot_idx_t'(1)) begin
          h_re       = 1'b1;
          state_next = S_UPW;
        end else begin
          state_next = S_PLACE;
        end
      end

      S_UPW: begin
        if (h_rd.cost >= cost) begin
          h_we       = 1'b1;
          h_wd       = h_rd;
          m_we       = 1'b1;
          m_wa       = h_rd.col;
          k_next     = k >> 1;
          state_next = S_UP;
        end else begin
          state_next = S_PLACE;
        end
      end

      S_DN: begin
        if (j2 > {1'b0, size}) begin
          state_next = S_PLACE;
        end else begin
          j_next     = j2[SLOT_W-1:0];
          h_re       = 1'b1;
          h_ra       = slot_addr(j2[SLOT_W-1:0]);
          state_next = S_DNL;
        end
      end

      S_DNL, S_DNR: begin
        if (state == S_DNL) begin
          ch        = h_rd;
          left_next = h_rd;
        end else if (left.cost > h_rd.cost) begin
          ch      = h_rd;
          ch_slot = j + slot_idx_t'(1);
        end
        if (state == S_DNL && j < size) begin
          h_re       = 1'b1;
          h_ra       = slot_addr(j + slot_idx_t'(1));
          state_next = S_DNR;
        end else if (cost <= ch.cost) begin
          state_next = S_PLACE;
        end else begin
          h_we       = 1'b1;
          h_wd       = ch;
          m_we       = 1'b1;
          m_wa       = ch.col;
          k_next     = ch_slot;
          state_next = S_DN;
        end
      end

      S_PLACE: begin
        h_we       = 1'b1;
        m_we       = 1'b1;
        state_next = S_ROOT;
      end

      S_ROOT: begin
        h_re       = 1'b1;
        h_ra       = '0;
        state_next = S_ROOTW;
      end

      S_ROOTW: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_col_next    = (size == '0) ? '0 : h_rd.col;
          out_cost_next   = (size == '0) ? '0 : h_rd.cost;
          out_count_next  = size;
          out_status_next = status;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size      <= '0;
      clr_cnt   <= '0;
      clr_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      size      <= size_next;
      clr_cnt   <= clr_cnt_next;
      clr_done  <= clr_done_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    j          <= j_next;
    op         <= op_next;
    col        <= col_next;
    cost       <= cost_next;
    left       <= left_next;
    status     <= status_next;
    out_col    <= out_col_next;
    out_cost   <= out_cost_next;
    out_count  <= out_count_next;
    out_status <= out_status_next;
  end

  // The heap never holds more than its capacity.
  `IMHK_ASSERT_ALWAYS(a_size_bound, size <= slot_idx_t'(CAPACITY), "heap size beyond capacity")

  // Every heap write lands on an occupied slot.
  `IMHK_ASSERT_IMPLY(a_write_in_heap, h_we, (k != '0) && (k <= size), "heap write off the heap")

  // No request is taken before the position map has been cleared.
  `IMHK_ASSERT_IMPLY(a_accept_after_clear, req.valid && req.ready, clr_done, "request while clearing")

endmodule
